// ===== src/lksc_pkg.sv =====
// ----------------------------------------------------------------------------
// lksc_pkg: LRU keyed slot cache shared definitions
// Sizes, slot and count types, and the controller/datapath interface structs.
// ----------------------------------------------------------------------------
package lksc_pkg;

    localparam int ENTRIES    = 32;
    localparam int SLOT_W     = $clog2(ENTRIES);
    localparam int CNT_W      = $clog2(ENTRIES + 1);
    localparam int KEY_W      = 32;
    localparam int SLOT_OUT_W = 5;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [CNT_W-1:0]  t_cnt;
    typedef logic [KEY_W-1:0]  t_key;

    typedef struct packed {
        logic load;
        logic scan;
        logic finish_hit;
        logic finish_alloc;
        logic finish_evict;
        logic flush_step;
        logic flush_end;
    } t_dp_cmd;

    typedef struct packed {
        logic match;
        logic scan_end;
        logic full;
        logic flush_done;
    } t_dp_status;

endpackage

// ===== src/lksc_datapath.sv =====
// ----------------------------------------------------------------------------
// lksc_datapath: tag store, recency list and free queue
// Walks the recency list one entry a cycle against the tag memory, reorders
// the list, allocates and evicts slots, and returns slots on a flush.
// ----------------------------------------------------------------------------
module lksc_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  lksc_pkg::t_dp_cmd                    i_cmd,
    input  lksc_pkg::t_key                       i_key,
    output lksc_pkg::t_dp_status                 o_status,
    output logic                                 o_hit,
    output logic [lksc_pkg::SLOT_OUT_W-1:0]      o_slot,
    output logic                                 o_evicted_valid,
    output lksc_pkg::t_key                       o_evicted_key
);

    localparam int SUM_W = lksc_pkg::CNT_W + 1;

    lksc_pkg::t_key  r_tags [lksc_pkg::ENTRIES];
    lksc_pkg::t_slot r_rec  [lksc_pkg::ENTRIES];
    lksc_pkg::t_slot n_rec  [lksc_pkg::ENTRIES];
    lksc_pkg::t_slot r_fq   [lksc_pkg::ENTRIES];
    lksc_pkg::t_slot n_fq   [lksc_pkg::ENTRIES];

    lksc_pkg::t_key  r_key;
    lksc_pkg::t_cnt  r_used;
    lksc_pkg::t_slot r_head;
    lksc_pkg::t_cnt  r_idx;
    lksc_pkg::t_slot r_wr_ptr;
    logic            r_cmp_v;
    lksc_pkg::t_slot r_cmp_pos;
    lksc_pkg::t_slot r_cmp_slot;
    lksc_pkg::t_key  r_tag_q;
    lksc_pkg::t_key  r_ev_key;
    logic            r_hit;
    lksc_pkg::t_slot r_slot;
    logic            r_ev_valid;
    lksc_pkg::t_key  r_ev_key_out;

    lksc_pkg::t_slot rd_slot;
    logic            issue;
    lksc_pkg::t_cnt  free_cnt;
    logic [SUM_W-1:0] tail_sum;
    lksc_pkg::t_slot tail;
    lksc_pkg::t_slot head_inc;
    lksc_pkg::t_slot wr_ptr_inc;
    lksc_pkg::t_slot alloc_slot;
    lksc_pkg::t_slot mtt_slot;
    lksc_pkg::t_cnt  mtt_pos;
    lksc_pkg::t_cnt  last_pos;
    logic            mtt_en;
    logic            tag_we;
    lksc_pkg::t_slot tag_waddr;

    assign rd_slot    = r_rec[r_idx[lksc_pkg::SLOT_W-1:0]];
    assign issue      = i_cmd.scan && (r_idx != r_used);
    assign free_cnt   = lksc_pkg::CNT_W'(lksc_pkg::ENTRIES) - r_used;
    assign tail_sum   = SUM_W'(r_head) + SUM_W'(free_cnt);
    assign tail       = (tail_sum >= SUM_W'(lksc_pkg::ENTRIES))
                        ? lksc_pkg::SLOT_W'(tail_sum - SUM_W'(lksc_pkg::ENTRIES))
                        : lksc_pkg::SLOT_W'(tail_sum);
    assign head_inc   = (r_head == lksc_pkg::SLOT_W'(lksc_pkg::ENTRIES - 1))
                        ? '0 : r_head + 1'b1;
    assign wr_ptr_inc = (r_wr_ptr == lksc_pkg::SLOT_W'(lksc_pkg::ENTRIES - 1))
                        ? '0 : r_wr_ptr + 1'b1;
    assign alloc_slot = r_fq[r_head];
    assign mtt_en     = i_cmd.finish_hit || i_cmd.finish_evict;
    assign mtt_slot   = i_cmd.finish_hit ? r_cmp_slot : r_rec[0];
    assign mtt_pos    = i_cmd.finish_hit ? lksc_pkg::CNT_W'(r_cmp_pos) : '0;
    assign last_pos   = r_used - 1'b1;
    assign tag_we     = i_cmd.finish_alloc || i_cmd.finish_evict;
    assign tag_waddr  = i_cmd.finish_alloc ? alloc_slot : r_rec[0];

    always_comb begin
        for (int j = 0; j < lksc_pkg::ENTRIES; j++) begin
            n_rec[j] = r_rec[j];
            n_fq[j]  = r_fq[j];
        end
        if (mtt_en) begin
            for (int j = 0; j < lksc_pkg::ENTRIES - 1; j++) begin
                if ((lksc_pkg::CNT_W'(j) >= mtt_pos) &&
                    (lksc_pkg::CNT_W'(j + 1) < r_used)) begin
                    n_rec[j] = r_rec[j + 1];
                end
            end
            n_rec[last_pos[lksc_pkg::SLOT_W-1:0]] = mtt_slot;
        end
        if (i_cmd.finish_alloc) begin
            n_rec[r_used[lksc_pkg::SLOT_W-1:0]] = alloc_slot;
        end
        if (i_cmd.flush_step) begin
            n_fq[r_wr_ptr] = rd_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (tag_we) begin
            r_tags[tag_waddr] <= r_key;
        end
        if (issue) begin
            r_tag_q <= r_tags[rd_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        for (int j = 0; j < lksc_pkg::ENTRIES; j++) begin
            r_rec[j] <= n_rec[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < lksc_pkg::ENTRIES; j++) begin
                r_fq[j] <= lksc_pkg::SLOT_W'(j);
            end
            r_used  <= '0;
            r_head  <= '0;
            r_cmp_v <= 1'b0;
        end else begin
            for (int j = 0; j < lksc_pkg::ENTRIES; j++) begin
                r_fq[j] <= n_fq[j];
            end
            if (i_cmd.finish_alloc) begin
                r_used <= r_used + 1'b1;
                r_head <= head_inc;
            end else if (i_cmd.flush_end) begin
                r_used <= '0;
            end
            r_cmp_v <= issue;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_key    <= i_key;
            r_idx    <= '0;
            r_wr_ptr <= tail;
        end else if (issue) begin
            r_idx <= r_idx + 1'b1;
        end else if (i_cmd.flush_step) begin
            r_idx    <= r_idx + 1'b1;
            r_wr_ptr <= wr_ptr_inc;
        end
        if (issue) begin
            r_cmp_pos  <= r_idx[lksc_pkg::SLOT_W-1:0];
            r_cmp_slot <= rd_slot;
        end
        if (r_cmp_v && (r_cmp_pos == '0)) begin
            r_ev_key <= r_tag_q;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish_hit) begin
            r_hit        <= 1'b1;
            r_slot       <= r_cmp_slot;
            r_ev_valid   <= 1'b0;
            r_ev_key_out <= '0;
        end else if (i_cmd.finish_alloc) begin
            r_hit        <= 1'b0;
            r_slot       <= alloc_slot;
            r_ev_valid   <= 1'b0;
            r_ev_key_out <= '0;
        end else if (i_cmd.finish_evict) begin
            r_hit        <= 1'b0;
            r_slot       <= r_rec[0];
            r_ev_valid   <= 1'b1;
            r_ev_key_out <= r_ev_key;
        end else if (i_cmd.flush_end) begin
            r_hit        <= 1'b0;
            r_slot       <= '0;
            r_ev_valid   <= 1'b0;
            r_ev_key_out <= '0;
        end
    end

    assign o_status.match      = r_cmp_v && (r_tag_q == r_key);
    assign o_status.scan_end   = !r_cmp_v && (r_idx == r_used);
    assign o_status.full       = (r_used == lksc_pkg::CNT_W'(lksc_pkg::ENTRIES));
    assign o_status.flush_done = (r_idx == r_used);

    assign o_hit           = r_hit;
    assign o_slot          = lksc_pkg::SLOT_OUT_W'(r_slot);
    assign o_evicted_valid = r_ev_valid;
    assign o_evicted_key   = r_ev_key_out;

endmodule

// ===== src/lksc_ctrl.sv =====
// ----------------------------------------------------------------------------
// lksc_ctrl: LRU keyed slot cache controller
// Sequences the tag walk, the hit/allocate/evict update and the flush sweep.
// ----------------------------------------------------------------------------
module lksc_ctrl (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_start,
    input  logic                 i_func,
    input  lksc_pkg::t_dp_status i_status,
    output lksc_pkg::t_dp_cmd    o_cmd,
    output logic                 o_busy,
    output logic                 o_valid
);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_FLUSH = 4'b0100,
        S_DONE  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_func ? S_FLUSH : S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_status.match) begin
                    o_cmd.finish_hit = 1'b1;
                    n_state          = S_DONE;
                end else if (i_status.scan_end) begin
                    o_cmd.finish_evict = i_status.full;
                    o_cmd.finish_alloc = !i_status.full;
                    n_state            = S_DONE;
                end else begin
                    o_cmd.scan = 1'b1;
                end
            end
            S_FLUSH: begin
                if (i_status.flush_done) begin
                    o_cmd.flush_end = 1'b1;
                    n_state         = S_DONE;
                end else begin
                    o_cmd.flush_step = 1'b1;
                end
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

// ===== src/lru_keyed_slot_cache.sv =====
// ----------------------------------------------------------------------------
// lru_keyed_slot_cache: fully associative LRU slot directory
// Lookup: walks the recency list one slot a cycle through the tag memory.
// Flush: returns the used slots to the free queue.
// One item at a time; the next item is taken the cycle after the result
// strobe, and results are never held off.
// Synchronous reset empties the directory and refills the free queue at once.
// ----------------------------------------------------------------------------
module lru_keyed_slot_cache (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic                            i_func,
    input  logic [lksc_pkg::KEY_W-1:0]      i_key,
    output logic                            o_valid,
    output logic                            o_hit,
    output logic [lksc_pkg::SLOT_OUT_W-1:0] o_slot,
    output logic                            o_evicted_valid,
    output logic [lksc_pkg::KEY_W-1:0]      o_evicted_key
);

    lksc_pkg::t_dp_cmd    cmd;
    lksc_pkg::t_dp_status status;

    lksc_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_func   (i_func),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    lksc_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .i_key           (i_key),
        .o_status        (status),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key)
    );

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted item did not raise busy");

    a_strobe_single: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    a_evict_not_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_evicted_valid) |-> !o_hit)
        else $error("eviction reported on a hit");

    a_evict_key_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted_valid) |-> (o_evicted_key == '0))
        else $error("evicted key nonzero without eviction");

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top: LRU keyed slot cache testbench
// Drives lookups and flushes through the start/busy handshake with random
// gaps, predicts each result with an in-bench LRU directory and free queue,
// and compares every strobed result field by field in arrival order.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam bit FUNC_LOOKUP = 1'b0;
    localparam bit FUNC_FLUSH  = 1'b1;
    localparam int STALL_LIMIT = 1000;
    localparam int DRAIN_WAIT  = lksc_pkg::ENTRIES + 16;
    localparam int POOL_SIZE   = 40;

    typedef struct packed {
        logic                            hit;
        logic [lksc_pkg::SLOT_OUT_W-1:0] slot;
        logic                            evicted_valid;
        lksc_pkg::t_key                  evicted_key;
    } t_lookup_result;

    logic                            i_clk = 1'b0;
    logic                            i_rst_n = 1'b0;
    logic                            start = 1'b0;
    logic                            busy;
    logic                            i_func = 1'b0;
    lksc_pkg::t_key                  i_key = '0;
    logic                            o_valid;
    logic                            o_hit;
    logic [lksc_pkg::SLOT_OUT_W-1:0] o_slot;
    logic                            o_evicted_valid;
    lksc_pkg::t_key                  o_evicted_key;

    lksc_pkg::t_key  slot_key_mem [lksc_pkg::ENTRIES];
    lksc_pkg::t_slot recency_order[$];
    lksc_pkg::t_slot free_slots[$];
    t_lookup_result  pending_results[$];
    int              error_count = 0;
    int              stall_cycles = 0;
    bit              no_gaps = 1'b0;

    lru_keyed_slot_cache DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .start           (start),
        .busy            (busy),
        .i_func          (i_func),
        .i_key           (i_key),
        .o_valid         (o_valid),
        .o_hit           (o_hit),
        .o_slot          (o_slot),
        .o_evicted_valid (o_evicted_valid),
        .o_evicted_key   (o_evicted_key)
    );

    initial begin
        forever #2 i_clk = ~i_clk;
    end

    function automatic t_lookup_result predict_lookup(bit func, lksc_pkg::t_key key);
        t_lookup_result  res;
        lksc_pkg::t_slot s;
        int              found;
        res   = '0;
        found = -1;
        if (func == FUNC_FLUSH) begin
            foreach (recency_order[i]) free_slots.push_back(recency_order[i]);
            recency_order.delete();
        end else begin
            for (int i = 0; i < recency_order.size(); i++) begin
                if (slot_key_mem[recency_order[i]] == key) begin
                    found = i;
                    break;
                end
            end
            if (found >= 0) begin
                s = recency_order[found];
                recency_order.delete(found);
                res.hit = 1'b1;
            end else if (recency_order.size() < lksc_pkg::ENTRIES) begin
                s = free_slots.pop_front();
                slot_key_mem[s] = key;
            end else begin
                s = recency_order.pop_front();
                res.evicted_valid = 1'b1;
                res.evicted_key   = slot_key_mem[s];
                slot_key_mem[s]   = key;
            end
            recency_order.push_back(s);
            res.slot = lksc_pkg::SLOT_OUT_W'(s);
        end
        return res;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_gaps || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    task automatic send_item(bit func, lksc_pkg::t_key key);
        int gap;
        gap = pick_gap();
        if (gap > 0) begin
            start  <= 1'b0;
            i_func <= $urandom_range(0, 1);
            i_key  <= $urandom;
            repeat (gap) @(posedge i_clk);
        end
        start  <= 1'b1;
        i_func <= func;
        i_key  <= key;
        do @(posedge i_clk); while (busy !== 1'b0);
        pending_results.push_back(predict_lookup(func, key));
    endtask

    task automatic wait_for_results();
        start <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic test_directed();
        send_item(FUNC_FLUSH, 32'h0000_0000);
        send_item(FUNC_LOOKUP, 32'h0000_0000);
        send_item(FUNC_LOOKUP, 32'h0000_0000);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h0000_0000);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h5555_5555);
        send_item(FUNC_LOOKUP, 32'hAAAA_AAAA);
        send_item(FUNC_LOOKUP, 32'h8000_0000);
        send_item(FUNC_LOOKUP, 32'h0000_0001);
        send_item(FUNC_LOOKUP, 32'h5555_5555);
        send_item(FUNC_FLUSH, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h0000_0000);
        send_item(FUNC_LOOKUP, 32'hFFFF_FFFF);
        send_item(FUNC_LOOKUP, 32'h0000_0000);
        send_item(FUNC_FLUSH, 32'h0000_0000);
    endtask

    task automatic test_fill_and_evict();
        lksc_pkg::t_key fill_keys[lksc_pkg::ENTRIES];
        lksc_pkg::t_key base;
        base = $urandom;
        for (int i = 0; i < lksc_pkg::ENTRIES; i++) begin
            fill_keys[i] = base + lksc_pkg::t_key'(i * 7919);
            send_item(FUNC_LOOKUP, fill_keys[i]);
        end
        send_item(FUNC_LOOKUP, fill_keys[0]);
        for (int i = 0; i < 8; i++) send_item(FUNC_LOOKUP, $urandom);
        send_item(FUNC_LOOKUP, fill_keys[1]);
        send_item(FUNC_LOOKUP, fill_keys[0]);
        send_item(FUNC_LOOKUP, fill_keys[lksc_pkg::ENTRIES-1]);
        wait_for_results();
        send_item(FUNC_FLUSH, $urandom);
        for (int i = 0; i < 6; i++) send_item(FUNC_LOOKUP, fill_keys[i]);
        send_item(FUNC_FLUSH, $urandom);
    endtask

    task automatic test_random(int n_items);
        lksc_pkg::t_key key_pool[POOL_SIZE];
        int             r;
        key_pool[0] = 32'h0000_0000;
        key_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
        for (int n = 0; n < n_items; n++) begin
            if (n % 50 == 0) no_gaps = ($urandom_range(0, 2) == 0);
            if (n == n_items / 2) wait_for_results();
            r = $urandom_range(0, 99);
            if (r < 2) send_item(FUNC_FLUSH, $urandom);
            else if (r < 15) send_item(FUNC_LOOKUP, $urandom);
            else send_item(FUNC_LOOKUP, key_pool[$urandom_range(0, POOL_SIZE - 1)]);
        end
        no_gaps = 1'b0;
    endtask

    always @(posedge i_clk) begin : check_result
        t_lookup_result want;
        if (i_rst_n && o_valid) begin
            if (pending_results.size() == 0) begin
                $error("result strobe with no item pending");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (o_hit !== want.hit) begin
                    $error("hit: expected %0d, got %0d", want.hit, o_hit);
                    error_count++;
                end
                if (o_slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, o_slot);
                    error_count++;
                end
                if (o_evicted_valid !== want.evicted_valid) begin
                    $error("evicted_valid: expected %0d, got %0d",
                           want.evicted_valid, o_evicted_valid);
                    error_count++;
                end
                if (o_evicted_key !== want.evicted_key) begin
                    $error("evicted_key: expected %h, got %h",
                           want.evicted_key, o_evicted_key);
                    error_count++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && busy === 1'b0) || o_valid === 1'b1) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
            if (stall_cycles + 1 >= STALL_LIMIT) begin
                $display("tb_top failed");
                $finish;
            end
        end
    end

    initial begin
        for (int i = 0; i < lksc_pkg::ENTRIES; i++) begin
            free_slots.push_back(lksc_pkg::t_slot'(i));
        end
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_fill_and_evict();
        test_random(330);
        wait_for_results();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_results.size() != 0) begin
            $error("%0d results never arrived", pending_results.size());
            error_count++;
        end
        if (error_count == 0) begin
            $display("tb_top passed");
        end else begin
            $display("tb_top failed");
        end
        $finish;
    end

endmodule
